[design/pwmlv_pkg.sv]
package pwmlv_pkg;

   // Defaults for the top-level parameters.
   localparam int COS_INDEX_BITS_DEFAULT = 10;
   localparam int SUM_WIDTH_DEFAULT      = 48;

   // Fixed field and register widths.
   localparam int LEVEL_WIDTH    = 4;
   localparam int STEP_WIDTH     = 32;
   localparam int SCALE_WIDTH    = 24;
   localparam int COEF_WIDTH     = 32;
   localparam int COS_MAG_WIDTH  = 15;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;

   // Register index, taken from paddr bit 2.
   typedef enum logic {
      REG_PHASE_STEP   = 1'b0,
      REG_OUTPUT_SCALE = 1'b1
   } reg_index_type;

   // One sample after the phase and cosine lookup stage.
   typedef struct packed {
      logic                          valid;
      logic                          first;
      logic                          last;
      logic                          negate;
      logic signed [LEVEL_WIDTH-1:0] level;
      logic [COS_MAG_WIDTH-1:0]      cos_mag;
   } cos_stage_type;

endpackage

[design/pwmlv_ifs.sv]
interface pwmlv_req_if import pwmlv_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [LEVEL_WIDTH-1:0] level;
   logic                          last;

   modport source (output valid, level, last, input ready);
   modport sink (input valid, level, last, output ready);
endinterface

interface pwmlv_rsp_if import pwmlv_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [COEF_WIDTH-1:0] coefficient;

   modport source (output valid, coefficient, input ready);
   modport sink (input valid, coefficient, output ready);
endinterface

[design/pwmlv_csr.sv]
module pwmlv_csr import pwmlv_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic [STEP_WIDTH-1:0]     phase_step,
   output logic [SCALE_WIDTH-1:0]    output_scale
);

   logic [STEP_WIDTH-1:0]  phase_step_ff;
   logic [SCALE_WIDTH-1:0] output_scale_ff;
   reg_index_type          index;
   logic                   write_strobe;

   assign index        = reg_index_type'(paddr[2]);
   assign write_strobe = psel && penable && pwrite;

   // Register writes complete in the access cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff   <= '0;
         output_scale_ff <= '0;
      end else if (write_strobe) begin
         unique case (index)
            REG_PHASE_STEP:   phase_step_ff   <= pwdata[STEP_WIDTH-1:0];
            REG_OUTPUT_SCALE: output_scale_ff <= pwdata[SCALE_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // Read data is zero-extended.
   always_comb begin
      unique case (index)
         REG_PHASE_STEP:   prdata = CSR_DATA_WIDTH'(phase_step_ff);
         REG_OUTPUT_SCALE: prdata = CSR_DATA_WIDTH'(output_scale_ff);
         default:          prdata = '0;
      endcase
   end

   assign phase_step   = phase_step_ff;
   assign output_scale = output_scale_ff;

endmodule

[design/pwmlv_phase.sv]
module pwmlv_phase import pwmlv_pkg::*; #(
   parameter int COS_INDEX_BITS = COS_INDEX_BITS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          req_valid,
   input  logic signed [LEVEL_WIDTH-1:0] req_level,
   input  logic                          req_last,
   input  logic [STEP_WIDTH-1:0]         phase_step,
   output cos_stage_type                 stage
);

   localparam int QBITS        = COS_INDEX_BITS - 2;
   localparam int QUARTER_SIZE = 1 << QBITS;
   localparam logic [QBITS:0] ROM_ADDR_TOP = (QBITS + 1)'(QUARTER_SIZE);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned TAYLOR_DIV [9] = '{2, 12, 30, 56, 90, 132, 182, 240, 306};

   typedef logic [QUARTER_SIZE:0][COS_MAG_WIDTH-1:0] rom_type;

   // Quarter-wave cosine in Q1.15 from a Q30 Taylor series.
   function automatic logic [COS_MAG_WIDTH-1:0] cos_quarter(int unsigned j);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] scaled;
      longint      acc;
      x    = (64'(j) * HALF_PI_Q30) >> QBITS;
      x2   = (x * x) >> 30;
      term = 64'd1 << 30;
      acc  = longint'(term);
      for (int n = 1; n <= 9; n++) begin
         term = ((term * x2) >> 30) / 64'(TAYLOR_DIV[n-1]);
         if (n % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      scaled = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      return scaled[COS_MAG_WIDTH-1:0];
   endfunction

   function automatic rom_type build_rom();
      rom_type r;
      for (int j = 0; j <= QUARTER_SIZE; j++) begin
         r[j] = cos_quarter(j);
      end
      return r;
   endfunction

   localparam rom_type QUARTER_ROM = build_rom();

   logic                      started_ff;
   logic [STEP_WIDTH-1:0]     phase_acc_ff;
   logic [STEP_WIDTH-1:0]     phase_in;
   logic [COS_INDEX_BITS-1:0] cos_index;
   logic [1:0]                quad;
   logic [QBITS-1:0]          quarter_pos;
   logic [QBITS:0]            rom_addr;
   cos_stage_type             stage_ff;

   // The first sample of a period sits at phase zero.
   assign phase_in    = started_ff ? phase_acc_ff + phase_step : '0;
   assign cos_index   = phase_in[STEP_WIDTH-1 -: COS_INDEX_BITS];
   assign quad        = cos_index[COS_INDEX_BITS-1 -: 2];
   assign quarter_pos = cos_index[QBITS-1:0];

   // Odd quadrants read the quarter wave mirrored.
   assign rom_addr = quad[0] ? ROM_ADDR_TOP - {1'b0, quarter_pos} : {1'b0, quarter_pos};

   // Phase accumulator, period tracking and the synchronous ROM read.
   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff     <= 1'b0;
         phase_acc_ff   <= '0;
         stage_ff.valid <= 1'b0;
      end else if (advance) begin
         stage_ff.valid <= req_valid;
         if (req_valid) begin
            started_ff   <= !req_last;
            phase_acc_ff <= phase_in;
         end
      end
      if (advance) begin
         stage_ff.first   <= !started_ff;
         stage_ff.last    <= req_last;
         stage_ff.negate  <= quad[1] ^ quad[0];
         stage_ff.level   <= req_level;
         stage_ff.cos_mag <= QUARTER_ROM[rom_addr];
      end
   end

   assign stage = stage_ff;

endmodule

[design/pwmlv_accum.sv]
module pwmlv_accum import pwmlv_pkg::*; #(
   parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  cos_stage_type               stage,
   output logic                        sum_valid,
   output logic signed [SUM_WIDTH-1:0] sum
);

   localparam int COS_WIDTH  = COS_MAG_WIDTH + 2;
   localparam int DIFF_WIDTH = COS_WIDTH + 1;
   localparam int TERM_WIDTH = DIFF_WIDTH + LEVEL_WIDTH;
   localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH - 1){1'b1}}};
   localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH - 1){1'b0}}};
   localparam logic signed [COS_WIDTH-1:0] COS_ZERO = COS_WIDTH'(32767);

   logic signed [LEVEL_WIDTH-1:0] held_level_ff;
   logic signed [COS_WIDTH-1:0]   seg_cos_ff;
   logic signed [SUM_WIDTH-1:0]   running_sum_ff;
   logic                          sum_valid_ff;
   logic signed [SUM_WIDTH-1:0]   sum_ff;

   logic signed [COS_WIDTH-1:0]   cur_cos;
   logic signed [DIFF_WIDTH-1:0]  cos_diff;
   logic signed [TERM_WIDTH-1:0]  term;
   logic signed [SUM_WIDTH:0]     wide_sum;
   logic signed [SUM_WIDTH-1:0]   sat_sum;
   logic                          close_seg;

   // Signed cosine at this sample.
   assign cur_cos = stage.negate ? -$signed({2'b00, stage.cos_mag})
                                 : $signed({2'b00, stage.cos_mag});

   // Closed segment contributes (start cos - current cos) * held level.
   assign cos_diff = DIFF_WIDTH'(seg_cos_ff) - DIFF_WIDTH'(cur_cos);
   assign term     = TERM_WIDTH'(cos_diff) * TERM_WIDTH'(held_level_ff);
   assign wide_sum = (SUM_WIDTH + 1)'(running_sum_ff) + (SUM_WIDTH + 1)'(term);

   // Saturate the running sum to its signed range.
   always_comb begin
      if (wide_sum[SUM_WIDTH] != wide_sum[SUM_WIDTH-1]) begin
         sat_sum = wide_sum[SUM_WIDTH] ? SUM_MIN : SUM_MAX;
      end else begin
         sat_sum = wide_sum[SUM_WIDTH-1:0];
      end
   end

   assign close_seg = (stage.level != held_level_ff) || stage.last;

   // Segment state and the finished sum of a period.
   always_ff @(posedge clock) begin
      if (reset) begin
         held_level_ff  <= '0;
         seg_cos_ff     <= COS_ZERO;
         running_sum_ff <= '0;
         sum_valid_ff   <= 1'b0;
      end else if (advance) begin
         sum_valid_ff <= stage.valid && stage.last;
         if (stage.valid) begin
            if (stage.first) begin
               held_level_ff  <= stage.level;
               seg_cos_ff     <= cur_cos;
               running_sum_ff <= '0;
            end else if (close_seg) begin
               held_level_ff  <= stage.level;
               seg_cos_ff     <= cur_cos;
               running_sum_ff <= sat_sum;
            end
         end
      end
      if (advance) begin
         sum_ff <= stage.first ? '0 : sat_sum;
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum       = sum_ff;

endmodule

[design/pwmlv_scale.sv]
module pwmlv_scale import pwmlv_pkg::*; #(
   parameter int SUM_WIDTH = SUM_WIDTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic                         sum_valid,
   input  logic signed [SUM_WIDTH-1:0]  sum,
   input  logic [SCALE_WIDTH-1:0]       output_scale,
   output logic                         out_valid,
   output logic signed [COEF_WIDTH-1:0] coefficient
);

   localparam int HI_WIDTH   = SUM_WIDTH - 32;
   localparam int PLO_WIDTH  = 32 + SCALE_WIDTH;
   localparam int PHI_WIDTH  = HI_WIDTH + SCALE_WIDTH;
   localparam int RND_WIDTH  = PLO_WIDTH - 15;
   localparam int V_WIDTH    = RND_WIDTH + 1;

   logic [SUM_WIDTH-1:0] mag;
   logic [PLO_WIDTH-1:0] p_lo;
   logic [PHI_WIDTH-1:0] p_hi;

   logic                 prod_valid_ff;
   logic                 neg_ff;
   logic [PLO_WIDTH-1:0] p_lo_ff;
   logic [PHI_WIDTH-1:0] p_hi_ff;

   logic                 hi_over;
   logic [RND_WIDTH-1:0] rounded;
   logic [V_WIDTH-1:0]   v;
   logic [31:0]          v_lim;
   logic [COEF_WIDTH-1:0] coef_in;

   logic                  out_valid_ff;
   logic [COEF_WIDTH-1:0] coef_ff;

   // Magnitude times scale, split into low and high partial products.
   assign mag  = sum[SUM_WIDTH-1] ? $unsigned(-sum) : $unsigned(sum);
   assign p_lo = PLO_WIDTH'(mag[31:0]) * PLO_WIDTH'(output_scale);
   assign p_hi = PHI_WIDTH'(mag[SUM_WIDTH-1:32]) * PHI_WIDTH'(output_scale);

   // Combine, round half away from zero and drop 15 bits.
   assign hi_over = |p_hi_ff[PHI_WIDTH-1:15];
   assign rounded = RND_WIDTH'((p_lo_ff + PLO_WIDTH'(16384)) >> 15);
   assign v       = hi_over ? V_WIDTH'(64'h1_0000_0000)
                            : V_WIDTH'({p_hi_ff[14:0], 17'b0}) + V_WIDTH'(rounded);

   // Saturate to the signed 32-bit range and restore the sign.
   always_comb begin
      if (neg_ff) begin
         v_lim   = (v > V_WIDTH'(64'h8000_0000)) ? 32'h8000_0000 : v[31:0];
         coef_in = 32'd0 - v_lim;
      end else begin
         v_lim   = (v > V_WIDTH'(64'h7FFF_FFFF)) ? 32'h7FFF_FFFF : v[31:0];
         coef_in = v_lim;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff <= sum_valid;
         out_valid_ff  <= prod_valid_ff;
      end
      if (advance) begin
         neg_ff  <= sum[SUM_WIDTH-1];
         p_lo_ff <= p_lo;
         p_hi_ff <= p_hi;
         coef_ff <= coef_in;
      end
   end

   assign out_valid   = out_valid_ff;
   assign coefficient = $signed(coef_ff);

endmodule

[design/pwm_line_voltage_harmonic.sv]
// A request's result passes the phase, accumulator, product and output registers in turn.
// Throughput: one request per cycle while no result waits; only requests marked last produce a result.
// The whole pipeline holds while a finished result waits on the response side.
// Reset is synchronous and active high; it clears the control registers, the period
// state and all valid flags, and needs no clearing pass.
module pwm_line_voltage_harmonic import pwmlv_pkg::*; #(
   parameter int COS_INDEX_BITS = COS_INDEX_BITS_DEFAULT,
   parameter int SUM_WIDTH      = SUM_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   pwmlv_req_if.sink                 req_chan,
   pwmlv_rsp_if.source               rsp_chan,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   logic [STEP_WIDTH-1:0]       phase_step;
   logic [SCALE_WIDTH-1:0]      output_scale;
   logic                        advance;
   cos_stage_type               stage;
   logic                        sum_valid;
   logic signed [SUM_WIDTH-1:0] sum;
   logic                        out_valid;

   // The pipeline moves unless a result is waiting at the output.
   assign advance        = !out_valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign rsp_chan.valid = out_valid;
   assign pready         = 1'b1;

   pwmlv_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .phase_step   (phase_step),
      .output_scale (output_scale)
   );

   pwmlv_phase #(
      .COS_INDEX_BITS (COS_INDEX_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req_valid  (req_chan.valid),
      .req_level  (req_chan.level),
      .req_last   (req_chan.last),
      .phase_step (phase_step),
      .stage      (stage)
   );

   pwmlv_accum #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_accum (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .stage     (stage),
      .sum_valid (sum_valid),
      .sum       (sum)
   );

   pwmlv_scale #(
      .SUM_WIDTH (SUM_WIDTH)
   ) u_scale (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .sum_valid    (sum_valid),
      .sum          (sum),
      .output_scale (output_scale),
      .out_valid    (out_valid),
      .coefficient  (rsp_chan.coefficient)
   );

endmodule

[tb/pwm_line_voltage_harmonic_test.sv]
`timescale 1ns / 1ps

module pwm_line_voltage_harmonic_test import pwmlv_pkg::*; ();

   localparam int COS_BITS = COS_INDEX_BITS_DEFAULT;
   localparam int QUARTER  = 1 << (COS_BITS - 2);
   localparam int SUM_BITS = SUM_WIDTH_DEFAULT;
   localparam longint SUM_MAX = (64'sd1 <<< (SUM_BITS - 1)) - 1;
   localparam longint SUM_MIN = -SUM_MAX - 1;
   localparam int SEGMENTS = 6;

   typedef enum {SHAPE_PWM, SHAPE_SWING, SHAPE_NOISE} shape_type;

   typedef struct {
      logic signed [LEVEL_WIDTH-1:0] level;
      logic                          last;
      bit                            drain;
   } sample_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      psel    = 1'b0;
   logic                      penable = 1'b0;
   logic                      pwrite  = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr   = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata  = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic                      pready;

   pwmlv_req_if req_if ();
   pwmlv_rsp_if rsp_if ();

   pwm_line_voltage_harmonic dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   always #1 clock = ~clock;

   // Stimulus and expectation stores.
   sample_type                   pending_samples[$];
   logic signed [COEF_WIDTH-1:0] expected_coefficients[$];
   int samples_queued   = 0;
   int samples_accepted = 0;
   int mismatch_count   = 0;
   int send_idle_pct    = 0;
   int recv_stall_pct   = 0;

   // Predictor state: register copies and the open period.
   logic [STEP_WIDTH-1:0]  cfg_step  = '0;
   logic [SCALE_WIDTH-1:0] cfg_scale = '0;
   int                     cos_quarter [0:QUARTER];
   int                     line_level  = 0;
   int                     open_cos    = 32767;
   logic [31:0]            angle       = '0;
   longint                 coef_sum    = 0;
   bit                     period_open = 1'b0;

   // Quarter-wave cosine table in Q1.15 from a fixed-point Taylor series.
   function automatic void build_cos_quarter();
      longint unsigned x, x2, term;
      longint acc;
      for (int j = 0; j <= QUARTER; j++) begin
         x = (longint'(j) * 64'd1686629713) >> (COS_BITS - 2);
         x2 = (x * x) >> 30;
         term = 64'd1 << 30;
         acc = 64'sd1073741824;
         for (int n = 1; n <= 9; n++) begin
            term = ((term * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
               acc = acc - longint'(term);
            end else begin
               acc = acc + longint'(term);
            end
         end
         if (acc < 0) begin
            acc = 0;
         end
         cos_quarter[j] = int'((longint'(acc) * 64'd32767 + (64'd1 << 29)) >> 30);
      end
   endfunction

   // Cosine at a phase, indexed by the top bits and mirrored by quadrant.
   function automatic int cos_at(input logic [31:0] phase);
      int unsigned index, quad, j;
      index = phase >> (32 - COS_BITS);
      quad = (index >> (COS_BITS - 2)) & 3;
      j = index & (QUARTER - 1);
      case (quad)
         0: return cos_quarter[j];
         1: return -cos_quarter[QUARTER - j];
         2: return -cos_quarter[j];
         default: return cos_quarter[QUARTER - j];
      endcase
   endfunction

   // Scale the sum by the Q9.15 factor, round half away from zero, saturate.
   function automatic logic signed [COEF_WIDTH-1:0] scaled_coefficient();
      longint unsigned mag, p_lo, p_hi, v;
      bit neg;
      neg = coef_sum < 0;
      mag = neg ? longint'(-coef_sum) : longint'(coef_sum);
      p_lo = (mag & 64'hFFFF_FFFF) * cfg_scale;
      p_hi = (mag >> 32) * cfg_scale;
      if (p_hi >= (64'd1 << 15)) begin
         v = 64'd1 << 32;
      end else begin
         v = (p_hi << 17) + ((p_lo + 64'd16384) >> 15);
      end
      if (!neg) begin
         return (v > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
      end
      if (v > 64'h8000_0000) begin
         v = 64'h8000_0000;
      end
      v = 64'd0 - v;
      return v[31:0];
   endfunction

   // Advance the period by one accepted sample; a last sample yields a coefficient.
   function automatic void predict_coefficient(input logic signed [LEVEL_WIDTH-1:0] level,
                                               input logic last);
      int lv;
      int now_cos;
      lv = int'(level);
      if (!period_open) begin
         line_level = lv;
         angle = '0;
         open_cos = cos_at('0);
         coef_sum = 0;
         period_open = 1'b1;
      end else begin
         angle = angle + cfg_step;
         now_cos = cos_at(angle);
         if (lv != line_level || last) begin
            coef_sum = coef_sum + longint'(open_cos - now_cos) * line_level;
            if (coef_sum > SUM_MAX) begin
               coef_sum = SUM_MAX;
            end else if (coef_sum < SUM_MIN) begin
               coef_sum = SUM_MIN;
            end
            open_cos = now_cos;
            line_level = lv;
         end
      end
      if (last) begin
         expected_coefficients.push_back(scaled_coefficient());
         period_open = 1'b0;
      end
   endfunction

   function automatic void push_sample(input logic signed [LEVEL_WIDTH-1:0] level,
                                       input logic last, input bit drain);
      sample_type s;
      s.level = level;
      s.last = last;
      s.drain = drain;
      pending_samples.push_back(s);
      samples_queued++;
   endfunction

   // One period (or an unfinished stretch of one) of a given waveform shape.
   function automatic void queue_period(input int length, input shape_type shape,
                                        input bit drain, input bit close);
      logic signed [LEVEL_WIDTH-1:0] lv;
      logic signed [LEVEL_WIDTH-1:0] swing_start;
      lv = LEVEL_WIDTH'($urandom_range(8) - 4);
      swing_start = LEVEL_WIDTH'($urandom_range(1) ? 7 : -8);
      for (int i = 0; i < length; i++) begin
         case (shape)
            SHAPE_PWM: begin
               if (i > 0 && $urandom_range(3) == 0) begin
                  lv = LEVEL_WIDTH'($urandom_range(8) - 4);
               end
            end
            SHAPE_SWING: begin
               lv = (i % 2 == 0) ? swing_start : ~swing_start;
            end
            default: begin
               lv = LEVEL_WIDTH'($urandom());
            end
         endcase
         push_sample(lv, close && (i == length - 1), drain && (i == 0));
      end
   endfunction

   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return 1;
      end else if (roll < 13) begin
         return $urandom_range(41, 120);
      end
      return $urandom_range(2, 40);
   endfunction

   // Random periods; a segment may end inside an open period.
   function automatic void queue_random(input int count, input bit allow_open);
      int pushed;
      int roll;
      int len;
      shape_type shape;
      pushed = 0;
      while (pushed < count) begin
         roll = $urandom_range(99);
         if (roll < 70) begin
            shape = SHAPE_PWM;
         end else if (roll < 85) begin
            shape = SHAPE_SWING;
         end else begin
            shape = SHAPE_NOISE;
         end
         len = pick_length();
         queue_period(len, shape, (pushed == 0) || ($urandom_range(14) == 0), 1'b1);
         pushed += len;
      end
      if (allow_open && $urandom_range(1)) begin
         queue_period($urandom_range(1, 5), SHAPE_PWM, 1'b0, 1'b0);
      end
   endfunction

   // Setup and access phase; the register takes the value at the access edge.
   task automatic write_csr(input reg_index_type index, input logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      psel <= 1'b0;
      penable <= 1'b0;
      case (index)
         REG_PHASE_STEP: cfg_step = value;
         default: cfg_scale = value[SCALE_WIDTH-1:0];
      endcase
   endtask

   // Wait until every request is accepted and every coefficient has come back.
   task automatic wait_idle();
      while (samples_accepted != samples_queued || expected_coefficients.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            predict_coefficient(req_if.level, req_if.last);
            samples_accepted++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct &&
                !(pending_samples[0].drain && expected_coefficients.size() > 0)) begin
               req_if.valid <= 1'b1;
               req_if.level <= pending_samples[0].level;
               req_if.last <= pending_samples[0].last;
               void'(pending_samples.pop_front());
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin : monitor
      logic signed [COEF_WIDTH-1:0] want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_coefficients.size() == 0) begin
               $error("coefficient: no result expected, actual %0d", rsp_if.coefficient);
               mismatch_count++;
            end else begin
               want = expected_coefficients.pop_front();
               if (rsp_if.coefficient !== want) begin
                  $error("coefficient: expected %0d, actual %0d", want, rsp_if.coefficient);
                  mismatch_count++;
               end
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Main sequence: configure, run a segment, drain, repeat.
   initial begin
      logic [31:0] step_value;
      logic [23:0] scale_value;
      req_if.valid = 1'b0;
      req_if.level = '0;
      req_if.last = 1'b0;
      rsp_if.ready = 1'b0;
      build_cos_quarter();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int seg = 0; seg < SEGMENTS; seg++) begin
         if (seg < 2) begin
            send_idle_pct = 7;
            recv_stall_pct = 77;
         end else if (seg < 4) begin
            send_idle_pct = 77;
            recv_stall_pct = 7;
         end else begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
         end
         case (seg)
            0: begin
               step_value = 32'h8000_0000;
               scale_value = 24'hFF_FFFF;
            end
            1: begin
               step_value = 32'hFFFF_FFFF;
               scale_value = 24'hFF_FFFF;
            end
            2: begin
               step_value = 32'h0000_0000;
               scale_value = 24'h00_0000;
            end
            3: begin
               step_value = 32'h0400_0000;
               scale_value = 24'd2670177;
            end
            4: begin
               step_value = 32'h1000_0000;
               scale_value = 24'd890059;
            end
            default: begin
               step_value = $urandom();
               scale_value = 24'($urandom());
            end
         endcase
         write_csr(REG_PHASE_STEP, step_value);
         write_csr(REG_OUTPUT_SCALE, {8'h00, scale_value});

         if (seg == 0) begin
            // A one-sample period, then every level with a change on the last sample.
            push_sample(LEVEL_WIDTH'(3), 1'b1, 1'b0);
            for (int v = -8; v <= 7; v++) begin
               push_sample(LEVEL_WIDTH'(v), v == 7, 1'b0);
            end
            // Full-scale swing at half-turn steps drives the output into saturation.
            for (int i = 0; i < 10; i++) begin
               push_sample(LEVEL_WIDTH'((i % 2 == 0) ? 7 : -8), i == 9, 1'b0);
            end
         end
         queue_random((seg == 2) ? 60 : 255, seg != SEGMENTS - 1);
         wait_idle();
      end

      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #400000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[filelist.f]
design/pwmlv_pkg.sv
design/pwmlv_ifs.sv
design/pwmlv_csr.sv
design/pwmlv_phase.sv
design/pwmlv_accum.sv
design/pwmlv_scale.sv
design/pwm_line_voltage_harmonic.sv
tb/pwm_line_voltage_harmonic_test.sv
